@@ hw/rtl/acd_pkg.sv @@
// Shared types, codes and character helpers for the ANSI-C escape decoder.
// Used by acd_decode, acd_res_fifo and ansi_c_escape_decoder; depends on nothing.
package acd_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChEsc    = 8'h1B;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_OCT1   = 3'd4,
    MODE_OCT2   = 3'd5,
    MODE_ERR    = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_token;
    logic       error;
  } res_t;

  // Up to two results per input beat.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_t;

  // {digit valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

  // {known escape, mapped character}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      ChBslash: r = {1'b1, ChBslash};
      8'h61:    r = {1'b1, 8'h07};
      8'h62:    r = {1'b1, 8'h08};
      8'h65:    r = {1'b1, ChEsc};
      8'h45:    r = {1'b1, ChEsc};
      8'h66:    r = {1'b1, 8'h0C};
      8'h6E:    r = {1'b1, 8'h0A};
      8'h72:    r = {1'b1, 8'h0D};
      8'h74:    r = {1'b1, 8'h09};
      8'h76:    r = {1'b1, 8'h0B};
      ChQuote:  r = {1'b1, ChQuote};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/acd_decode.sv @@
// Escape decoding state machine: mode, partial value and error flag, plus the
// results of one input beat. Depends on acd_pkg.
module acd_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          kind,
  input  logic [7:0]    in_byte,
  output acd_pkg::dec_t dec
);
  import acd_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] value, value_next;
  logic       err_seen, err_seen_next;
  logic [4:0] hx;
  logic [8:0] se;
  logic       oct;

  assign hx  = hex_digit(in_byte);
  assign se  = simple_escape(in_byte);
  assign oct = is_octal(in_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_NORMAL;
      value    <= 8'd0;
      err_seen <= 1'b0;
    end else if (step) begin
      mode     <= mode_next;
      value    <= value_next;
      err_seen <= err_seen_next;
    end
  end

  // Next state
  always_comb begin
    mode_next     = mode;
    value_next    = value;
    err_seen_next = err_seen;
    if (kind) begin
      mode_next     = MODE_NORMAL;
      value_next    = 8'd0;
      err_seen_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_ESC: begin
          mode_next = MODE_NORMAL;
          if (se[8]) begin
            mode_next = MODE_NORMAL;
          end else if (in_byte == ChX) begin
            mode_next  = MODE_HEX0;
            value_next = 8'd0;
          end else if (oct) begin
            mode_next  = MODE_OCT1;
            value_next = {5'd0, in_byte[2:0]};
          end
        end
        MODE_HEX0, MODE_HEX1: begin
          if (!hx[4]) begin
            mode_next     = MODE_ERR;
            value_next    = 8'd0;
            err_seen_next = 1'b1;
          end else if (mode == MODE_HEX0) begin
            mode_next  = MODE_HEX1;
            value_next = {4'd0, hx[3:0]};
          end else begin
            mode_next  = MODE_NORMAL;
            value_next = 8'd0;
          end
        end
        MODE_OCT1, MODE_OCT2: begin
          if (!oct) begin
            mode_next     = MODE_ERR;
            value_next    = 8'd0;
            err_seen_next = 1'b1;
          end else if (mode == MODE_OCT1) begin
            mode_next  = MODE_OCT2;
            value_next = {value[4:0], in_byte[2:0]};
          end else begin
            mode_next  = MODE_NORMAL;
            value_next = 8'd0;
          end
        end
        MODE_ERR: mode_next = MODE_ERR;
        default: begin
          mode_next = (in_byte == ChBslash) ? MODE_ESC : MODE_NORMAL;
        end
      endcase
    end
  end

  // Results
  always_comb begin
    dec = '0;
    if (kind) begin
      if (mode == MODE_ESC) begin
        dec.count = 2'd2;
        dec.r0    = '{out_byte: ChBslash, has_byte: 1'b1, end_of_token: 1'b0, error: 1'b0};
        dec.r1    = '{out_byte: 8'd0, has_byte: 1'b0, end_of_token: 1'b1, error: err_seen};
      end else begin
        dec.count = 2'd1;
        dec.r0    = '{out_byte: 8'd0, has_byte: 1'b0, end_of_token: 1'b1,
                      error: err_seen || mode == MODE_HEX0 || mode == MODE_HEX1 ||
                             mode == MODE_OCT1 || mode == MODE_OCT2};
      end
    end else begin
      unique case (mode)
        MODE_ESC: begin
          if (se[8]) begin
            dec.count = 2'd1;
            dec.r0    = '{out_byte: se[7:0], has_byte: 1'b1, end_of_token: 1'b0, error: 1'b0};
          end else if (in_byte != ChX && !oct) begin
            // unknown escape: backslash, then the byte as is
            dec.count = 2'd2;
            dec.r0    = '{out_byte: ChBslash, has_byte: 1'b1, end_of_token: 1'b0, error: 1'b0};
            dec.r1    = '{out_byte: in_byte, has_byte: 1'b1, end_of_token: 1'b0, error: 1'b0};
          end
        end
        MODE_HEX1: begin
          if (hx[4]) begin
            dec.count = 2'd1;
            dec.r0    = '{out_byte: {value[3:0], hx[3:0]}, has_byte: 1'b1,
                          end_of_token: 1'b0, error: 1'b0};
          end
        end
        MODE_OCT2: begin
          if (oct) begin
            dec.count = 2'd1;
            dec.r0    = '{out_byte: {value[4:0], in_byte[2:0]}, has_byte: 1'b1,
                          end_of_token: 1'b0, error: 1'b0};
          end
        end
        MODE_HEX0, MODE_OCT1, MODE_ERR: dec.count = 2'd0;
        default: begin
          if (in_byte != ChBslash) begin
            dec.count = 2'd1;
            dec.r0    = '{out_byte: in_byte, has_byte: 1'b1, end_of_token: 1'b0, error: 1'b0};
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/acd_res_fifo.sv @@
// Result queue: takes up to two results a cycle on push, gives one a cycle on pop.
// Depends on acd_pkg.
module acd_res_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  acd_pkg::dec_t dec,
  input  logic          pop,
  output logic          room,
  output logic          head_valid,
  output acd_pkg::res_t head
);
  import acd_pkg::*;

  res_t            mem [FifoDepth];
  logic [PtrW-1:0] wp, rp;
  logic [CntW-1:0] cnt, cnt_next;
  logic [CntW-1:0] n_in;

  assign n_in       = push ? CntW'(dec.count) : '0;
  assign room       = cnt <= CntW'(FifoDepth - 2);
  assign head_valid = cnt != '0;
  assign head       = mem[rp];
  assign cnt_next   = cnt + n_in - CntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + PtrW'(n_in);
      rp  <= rp + PtrW'(pop);
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && dec.count != 2'd0) begin
      mem[wp] <= dec.r0;
    end
    if (push && dec.count == 2'd2) begin
      mem[wp + PtrW'(1)] <= dec.r1;
    end
  end

endmodule

@@ hw/rtl/ansi_c_escape_decoder.sv @@
// Top level of the ANSI-C quoted string escape decoder: input register,
// decoder and result queue. Depends on acd_pkg, acd_decode, acd_res_fifo.
//
//   channel | beat                      | handshake
//   --------+---------------------------+----------------------
//   in      | kind, in_byte             | in_valid / in_stall
//   out     | out_byte, has_byte,       | out_valid / out_stall
//           | end_of_token, error       |
//
// One input beat is decoded per cycle while the queue has room for two results;
// a beat with two results leaves the queue one result at a time, through its
// single read port. A beat is held in the input register, its results in the queue.
// rst clears the decoder state, the input register and the queue.
// in_stall rises only when the input register is full and the queue lacks room
// for two results; out_stall holds the head result.
module ansi_c_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_token,
  output logic       error
);
  import acd_pkg::*;

  logic       in_full;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       room;
  logic       fire;
  logic       take;
  dec_t       dec;
  res_t       head;

  assign fire     = in_full && room;
  assign in_stall = in_full && !room;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= take || (in_full && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_q <= kind;
      byte_q <= in_byte;
    end
  end

  acd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (fire),
    .kind    (kind_q),
    .in_byte (byte_q),
    .dec     (dec)
  );

  acd_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .dec        (dec),
    .pop        (out_valid && !out_stall),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_byte     = head.out_byte;
  assign has_byte     = head.has_byte;
  assign end_of_token = head.end_of_token;
  assign error        = head.error;

endmodule
